// ===== hw/rtl/rhp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the RTP header parser.
// Used by the front end, descriptor queue, back end and top level; no dependencies.

package rhp_pkg;

	localparam int unsigned CNT_W  = 16;
	localparam int unsigned SIZE_W = CNT_W + 1;

	// Packets that reach this many bytes before their last byte are overlong.
	localparam logic [CNT_W-1:0] MAX_PACKET_BYTES = 16'd65535;
	localparam logic [CNT_W-1:0] IDX_SATURATED    = 16'hFFFF;

	// Byte positions inside the fixed header.
	localparam logic [CNT_W-1:0] POS_FLAGS     = 16'd0;
	localparam logic [CNT_W-1:0] POS_PT        = 16'd1;
	localparam logic [CNT_W-1:0] POS_SEQ_FIRST = 16'd2;
	localparam logic [CNT_W-1:0] POS_SEQ_LAST  = 16'd3;
	localparam logic [CNT_W-1:0] POS_TS_FIRST  = 16'd4;
	localparam logic [CNT_W-1:0] POS_TS_LAST   = 16'd7;
	localparam logic [CNT_W-1:0] POS_SSRC_FIRST = 16'd8;
	localparam logic [CNT_W-1:0] POS_SSRC_LAST  = 16'd11;
	localparam logic [CNT_W-1:0] FIXED_HDR_BYTES = 16'd12;

	// Extension length word sits two bytes into the extension header.
	localparam logic [6:0] EXT_LEN_POS_BASE = 7'd14;
	localparam logic [6:0] HDR_BASE_BYTES   = 7'd12;
	localparam logic [1:0] RTP_VERSION      = 2'd2;

	// Bits of the first header byte; the marker bit is in the second byte.
	localparam int unsigned BIT_PADDING   = 5;
	localparam int unsigned BIT_EXTENSION = 4;
	localparam int unsigned BIT_MARKER    = 7;

	localparam int unsigned DESC_DEPTH = 4;
	localparam int unsigned DESC_PTR_W = $clog2(DESC_DEPTH);

	localparam int unsigned OUT_DATA_W = 120;

	// Everything the back end needs to judge one finished packet.
	typedef struct packed {
		logic [7:0]        b0;
		logic [7:0]        b1;
		logic [15:0]       seq;
		logic [31:0]       ts;
		logic [31:0]       ssrc;
		logic [15:0]       ext_words;
		logic [SIZE_W-1:0] size;
		logic [7:0]        pad;
		logic              ovf;
	} desc_t;

	typedef struct packed {
		logic  push;
		desc_t desc;
	} wr_req_t;

	typedef struct packed {
		logic  nonempty;
		desc_t desc;
	} rd_side_t;

endpackage

// ===== hw/rtl/rtp_header_parser.sv =====
`timescale 1ns / 1ps
// Top level of the RTP header parser: front end, descriptor queue and back end.
// Depends on rhp_pkg, rhp_front, rhp_fifo and rhp_back.
//
//  Channel   Direction  Beat                 Sideband
//  s_*       in         one packet byte      tlast = last byte of the packet
//  m_*       out        one parsed header    tuser = packet passed all checks
//
// One byte is taken every cycle while s_tready is high, back to back across packet boundaries.
// After the last byte of its packet, a result passes through the descriptor queue and then
// the stage 1 and output registers of the check pipeline in the back end.
// s_tready drops only while the four-entry descriptor queue is full, that is when
// the result side stalls for several short packets in a row.
// Reset is asynchronous and clears the byte counter, queue and output valid.

module rtp_header_parser (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,  // [7:0] data_byte
	input  logic                           s_tlast,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [0] marker, [7:1] pay_type, [23:8] seq_num,
	// [55:24] media_timestamp, [87:56] source_id, [103:88] payload_offset,
	// [119:104] payload_length
	output logic [rhp_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                           m_tuser   // [0] valid_res
);
	import rhp_pkg::*;

	wr_req_t  wr;
	rd_side_t rd;
	logic     q_full;
	logic     pop;

	rhp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.wr       (wr)
	);

	rhp_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.full   (q_full),
		.pop    (pop),
		.rd     (rd)
	);

	rhp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd       (rd),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// ===== hw/rtl/rhp_front.sv =====
`timescale 1ns / 1ps
// Front end: counts packet bytes and captures header fields, one byte per cycle while the
// queue is not full. On the last byte it writes a packet descriptor into the queue. Depends on rhp_pkg.

module rhp_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,
	input  logic             s_tlast,
	input  logic             q_full,
	output rhp_pkg::wr_req_t wr
);
	import rhp_pkg::*;

	logic [CNT_W-1:0] idx_q, idx_d;
	logic             ovf_q, ovf_d, ovf_now;
	logic [7:0]       b0_q, b0_d;
	logic [7:0]       b1_q, b1_d;
	logic [15:0]      seq_q, seq_d;
	logic [31:0]      ts_q, ts_d;
	logic [31:0]      ssrc_q, ssrc_d;
	logic [15:0]      ext_q, ext_d;
	logic [6:0]       ext_pos;
	logic [CNT_W-1:0] ext_pos_w;
	logic             accept;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	assign ext_pos   = EXT_LEN_POS_BASE + {1'b0, b0_q[3:0], 2'b00};
	assign ext_pos_w = {{(CNT_W-7){1'b0}}, ext_pos};

	always_comb begin
		b0_d   = b0_q;
		b1_d   = b1_q;
		seq_d  = seq_q;
		ts_d   = ts_q;
		ssrc_d = ssrc_q;
		ext_d  = ext_q;
		if (idx_q == POS_FLAGS) begin
			b0_d = s_tdata;
		end else if (idx_q == POS_PT) begin
			b1_d = s_tdata;
		end else if (idx_q >= POS_SEQ_FIRST && idx_q <= POS_SEQ_LAST) begin
			seq_d = {seq_q[7:0], s_tdata};
		end else if (idx_q >= POS_TS_FIRST && idx_q <= POS_TS_LAST) begin
			ts_d = {ts_q[23:0], s_tdata};
		end else if (idx_q >= POS_SSRC_FIRST && idx_q <= POS_SSRC_LAST) begin
			ssrc_d = {ssrc_q[23:0], s_tdata};
		end
		// The length word follows the CSRC list; the CSRC count is already held in byte 0.
		if (idx_q >= FIXED_HDR_BYTES && (idx_q == ext_pos_w || idx_q == ext_pos_w + 16'd1)) begin
			ext_d = {ext_q[7:0], s_tdata};
		end

		ovf_now = ovf_q || (idx_q >= MAX_PACKET_BYTES);
		if (s_tlast) begin
			idx_d = '0;
			ovf_d = 1'b0;
		end else begin
			idx_d = (idx_q != IDX_SATURATED) ? idx_q + 16'd1 : idx_q;
			ovf_d = ovf_now;
		end

		wr.push           = accept && s_tlast;
		wr.desc.b0        = b0_d;
		wr.desc.b1        = b1_d;
		wr.desc.seq       = seq_d;
		wr.desc.ts        = ts_d;
		wr.desc.ssrc      = ssrc_d;
		wr.desc.ext_words = ext_d;
		wr.desc.size      = {1'b0, idx_q} + 17'd1;
		wr.desc.pad       = s_tdata;
		wr.desc.ovf       = ovf_now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			ovf_q  <= 1'b0;
			b0_q   <= '0;
			b1_q   <= '0;
			seq_q  <= '0;
			ts_q   <= '0;
			ssrc_q <= '0;
			ext_q  <= '0;
		end else if (accept) begin
			idx_q  <= idx_d;
			ovf_q  <= ovf_d;
			b0_q   <= b0_d;
			b1_q   <= b1_d;
			seq_q  <= seq_d;
			ts_q   <= ts_d;
			ssrc_q <= ssrc_d;
			ext_q  <= ext_d;
		end
	end

endmodule

// ===== hw/rtl/rhp_fifo.sv =====
`timescale 1ns / 1ps
// Short descriptor queue between the front end and the back end.
// Register based, one write and one read port. Depends on rhp_pkg.

module rhp_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  rhp_pkg::wr_req_t  wr,
	output logic              full,
	input  logic              pop,
	output rhp_pkg::rd_side_t rd
);
	import rhp_pkg::*;

	desc_t                 mem_q [DESC_DEPTH];
	logic [DESC_PTR_W-1:0] wr_ptr_q;
	logic [DESC_PTR_W-1:0] rd_ptr_q;
	logic [DESC_PTR_W:0]   count_q;
	logic                  do_push;
	logic                  do_pop;

	assign full        = (count_q == DESC_DEPTH[DESC_PTR_W:0]);
	assign rd.nonempty = (count_q != '0);
	assign rd.desc     = mem_q[rd_ptr_q];
	assign do_push     = wr.push && !full;
	assign do_pop      = pop && rd.nonempty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr.desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/rhp_back.sv =====
`timescale 1ns / 1ps
// Back end: checks one packet descriptor over two pipeline stages and holds the
// result in the output register. Depends on rhp_pkg.

module rhp_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rhp_pkg::rd_side_t                 rd,
	output logic                              pop,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [rhp_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic                              m_tuser
);
	import rhp_pkg::*;

	desc_t             d;
	logic [6:0]        base;
	logic [SIZE_W-1:0] base_w;
	logic [18:0]       ext_size;
	logic [SIZE_W-1:0] size_m_base;
	logic              base_ok, ext_ok, ok_a;
	logic [SIZE_W-1:0] hdr_a;
	logic              adv1, adv2;

	logic              valid_s1, ok_s1, pbit_s1;
	logic [SIZE_W-1:0] hdr_s1, size_s1;
	logic [7:0]        pad_s1, b1_s1;
	logic [15:0]       seq_s1;
	logic [31:0]       ts_s1, ssrc_s1;

	logic [SIZE_W-1:0] rem, pend;
	logic              pad_ok, ok_b;
	logic [15:0]       len;

	logic              out_valid_q, out_ok_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	assign d        = rd.desc;
	assign adv2     = !out_valid_q || m_tready;
	assign adv1     = !valid_s1 || adv2;
	assign pop      = rd.nonempty && adv1;
	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_ok_q;
	assign m_tdata  = out_data_q;

	// Stage 1: overlong packets, version, minimum length, CSRC list and extension fit.
	always_comb begin
		base        = HDR_BASE_BYTES + {1'b0, d.b0[3:0], 2'b00};
		base_w      = {{(SIZE_W-7){1'b0}}, base};
		ext_size    = 19'd4 + {1'b0, d.ext_words, 2'b00};
		size_m_base = d.size - base_w;
		base_ok     = !d.ovf && (d.size >= {1'b0, FIXED_HDR_BYTES})
		              && (d.b0[7:6] == RTP_VERSION) && (base_w <= d.size);
		ext_ok      = (base_w + 17'd4 <= d.size) && (ext_size <= {2'b00, size_m_base});
		ok_a        = base_ok && (!d.b0[BIT_EXTENSION] || ext_ok);
		// Once the extension fits, the header length fits in the size width.
		hdr_a       = d.b0[BIT_EXTENSION] ? (ext_size[SIZE_W-1:0] + base_w) : base_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv1) begin
			valid_s1 <= rd.nonempty;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			ok_s1   <= ok_a;
			pbit_s1 <= d.b0[BIT_PADDING];
			hdr_s1  <= hdr_a;
			size_s1 <= d.size;
			pad_s1  <= d.pad;
			b1_s1   <= d.b1;
			seq_s1  <= d.seq;
			ts_s1   <= d.ts;
			ssrc_s1 <= d.ssrc;
		end
	end

	// Stage 2: padding count and a non-empty payload.
	always_comb begin
		rem    = size_s1 - hdr_s1;
		pad_ok = !pbit_s1 || ((pad_s1 != 8'd0) && ({9'd0, pad_s1} <= rem));
		pend   = pbit_s1 ? size_s1 - {9'd0, pad_s1} : size_s1;
		ok_b   = ok_s1 && pad_ok && (pend > hdr_s1);
		len    = 16'(pend - hdr_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_ok_q    <= 1'b0;
		end else if (adv2) begin
			out_valid_q <= valid_s1;
			out_ok_q    <= ok_b;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			if (ok_b) begin
				out_data_q <= {len, hdr_s1[15:0], ssrc_s1, ts_s1, seq_s1,
				               b1_s1[6:0], b1_s1[BIT_MARKER]};
			end else begin
				out_data_q <= '0;
			end
		end
	end

endmodule

// ===== hw/rtl/rhp_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the RTP header parser, bound to the top level.
// Depends on rhp_pkg and rtp_header_parser.

module rhp_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [rhp_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                           m_tuser
);
	import rhp_pkg::*;

	// A result that is held back stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result transfer withdrawn while stalled");

	// A rejected packet reports all fields as zero.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("invalid packet carries nonzero fields");

	// An accepted packet always has payload left.
	a_valid_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[119:104] != 16'd0)
		else $error("valid packet with empty payload");

	// An accepted packet has at least the fixed header.
	a_valid_offset: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[103:88] >= FIXED_HDR_BYTES)
		else $error("valid packet with short header offset");

endmodule

bind rtp_header_parser rhp_checker u_rhp_checker (.*);

// ===== tb/rtp_header_parser_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for rtp_header_parser: drives RTP packets byte by byte and
// checks every parsed header against a predictor. Depends on rhp_pkg and the RTL only.

module rtp_header_parser_tb;

	import rhp_pkg::*;

	localparam int unsigned LIMIT        = 1_000_000;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned RANDOM_BYTES = 1200;
	localparam int unsigned FIXED_HDR    = 12;

	// Layout of m_tdata, marker in the lowest bit.
	typedef struct packed {
		logic [15:0] length;
		logic [15:0] offset;
		logic [31:0] ssrc;
		logic [31:0] ts;
		logic [15:0] seq;
		logic [6:0]  pt;
		logic        marker;
	} rtp_fields_t;

	typedef struct packed {
		logic        ok;
		rtp_fields_t f;
	} parsed_hdr_t;

	class header_book;
		logic [15:0] byte_cnt;
		logic        too_long;
		logic [7:0]  hdr0;
		logic [7:0]  hdr1;
		logic [15:0] seq_w;
		logic [31:0] ts_w;
		logic [31:0] ssrc_w;
		logic [15:0] ext_w;
		parsed_hdr_t due[$];
		int unsigned errors;

		function new();
			byte_cnt = '0;
			too_long = 1'b0;
			hdr0     = '0;
			hdr1     = '0;
			seq_w    = '0;
			ts_w     = '0;
			ssrc_w   = '0;
			ext_w    = '0;
			errors   = 0;
		endfunction

		function int unsigned pending();
			return due.size();
		endfunction

		// Called for every accepted byte; queues a header on the last one.
		function void note_byte(logic [7:0] b, logic last);
			int unsigned sz, hdr, pend, ext_pos, ext_sz;
			logic ok;
			parsed_hdr_t r;
			if (byte_cnt >= MAX_PACKET_BYTES)
				too_long = 1'b1;
			ext_pos = FIXED_HDR + 4 * hdr0[3:0] + 2;
			if (byte_cnt == 0)
				hdr0 = b;
			else if (byte_cnt == 1)
				hdr1 = b;
			else if (byte_cnt <= 3)
				seq_w = {seq_w[7:0], b};
			else if (byte_cnt <= 7)
				ts_w = {ts_w[23:0], b};
			else if (byte_cnt <= 11)
				ssrc_w = {ssrc_w[23:0], b};
			if (byte_cnt >= FIXED_HDR && (byte_cnt == ext_pos || byte_cnt == ext_pos + 1))
				ext_w = {ext_w[7:0], b};
			sz = 32'(byte_cnt) + 1;
			if (byte_cnt != IDX_SATURATED)
				byte_cnt = byte_cnt + 1;
			if (!last)
				return;

			hdr  = 0;
			pend = 0;
			ok   = !too_long && sz >= FIXED_HDR && hdr0[7:6] == RTP_VERSION;
			if (ok) begin
				hdr = FIXED_HDR + 4 * hdr0[3:0];
				if (hdr > sz)
					ok = 1'b0;
			end
			if (ok && hdr0[BIT_EXTENSION]) begin
				if (hdr + 4 > sz) begin
					ok = 1'b0;
				end else begin
					ext_sz = 4 + 4 * 32'(ext_w);
					if (ext_sz > sz - hdr)
						ok = 1'b0;
					else
						hdr = hdr + ext_sz;
				end
			end
			if (ok) begin
				pend = sz;
				if (hdr0[BIT_PADDING]) begin
					if (b == 0 || 32'(b) > sz - hdr)
						ok = 1'b0;
					else
						pend = pend - b;
				end
			end
			if (ok && pend <= hdr)
				ok = 1'b0;

			r = '0;
			if (ok) begin
				r.ok       = 1'b1;
				r.f.marker = hdr1[7];
				r.f.pt     = hdr1[6:0];
				r.f.seq    = seq_w;
				r.f.ts     = ts_w;
				r.f.ssrc   = ssrc_w;
				r.f.offset = hdr[15:0];
				r.f.length = 16'(pend - hdr);
			end
			due.push_back(r);
			byte_cnt = '0;
			too_long = 1'b0;
		endfunction

		function void compare(string name, longint unsigned want, longint unsigned got);
			if (want != got) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [OUT_DATA_W-1:0] data, logic user);
			parsed_hdr_t e;
			rtp_fields_t got;
			if (due.size() == 0) begin
				$error("header result with no packet pending: tdata=0x%h tuser=%b", data, user);
				errors++;
				return;
			end
			e   = due.pop_front();
			got = data;
			compare("valid_res", e.ok, user);
			compare("marker", e.f.marker, got.marker);
			compare("pay_type", e.f.pt, got.pt);
			compare("seq_num", e.f.seq, got.seq);
			compare("media_timestamp", e.f.ts, got.ts);
			compare("source_id", e.f.ssrc, got.ssrc);
			compare("payload_offset", e.f.offset, got.offset);
			compare("payload_length", e.f.length, got.length);
		endfunction
	endclass

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata  = '0;
	logic                  s_tlast  = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;

	header_book  book = new();
	logic [7:0]  pkt[$];
	int unsigned cycle_cnt  = 0;
	logic        hold_req   = 1'b0;
	logic        hold_taken = 1'b0;
	logic        rx_calm    = 1'b0;
	int unsigned rx_wait    = 0;
	int unsigned rx_gap;

	rtp_header_parser DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Mostly no gap, some short ones and a few long ones.
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Result side: check each transfer, then choose m_tready for the next cycle.
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			book.check_result(m_tdata, m_tuser);
		if (cycle_cnt[7:0] == 8'd0)
			rx_calm = ($urandom_range(0, 2) == 0);
		if (hold_req && !hold_taken) begin
			hold_taken = 1'b1;
			rx_wait    = HOLD_CYCLES;
		end
		if (rx_wait > 0) begin
			m_tready <= 1'b0;
			rx_wait = rx_wait - 1;
		end else begin
			rx_gap = rx_calm ? 0 : gap_len();
			m_tready <= (rx_gap == 0);
			rx_wait = (rx_gap > 0) ? rx_gap - 1 : 0;
		end
	end

	task automatic make_rtp(input logic [1:0] ver, input logic pad, input logic ext,
			input logic [3:0] cc, input logic mk, input logic [6:0] pt,
			input logic [15:0] seq, input logic [31:0] ts, input logic [31:0] ssrc,
			input logic [15:0] ext_words, input int pay_len, input int pad_fill,
			input logic [7:0] pad_val);
		pkt.delete();
		pkt.push_back({ver, pad, ext, cc});
		pkt.push_back({mk, pt});
		pkt.push_back(seq[15:8]);
		pkt.push_back(seq[7:0]);
		for (int i = 3; i >= 0; i--)
			pkt.push_back(ts[8*i +: 8]);
		for (int i = 3; i >= 0; i--)
			pkt.push_back(ssrc[8*i +: 8]);
		repeat (4 * cc)
			pkt.push_back(8'($urandom));
		if (ext) begin
			pkt.push_back(8'($urandom));
			pkt.push_back(8'($urandom));
			pkt.push_back(ext_words[15:8]);
			pkt.push_back(ext_words[7:0]);
			repeat (4 * ext_words)
				pkt.push_back(8'($urandom));
		end
		repeat (pay_len)
			pkt.push_back(8'($urandom));
		if (pad_fill > 0) begin
			repeat (pad_fill - 1)
				pkt.push_back(8'h00);
			pkt.push_back(pad_val);
		end
	endtask

	task automatic trim(input int n);
		while (pkt.size() > n)
			void'(pkt.pop_back());
	endtask

	task automatic send_packet(input logic calm);
		int unsigned gap;
		for (int i = 0; i < pkt.size(); i++) begin
			s_tdata  <= pkt[i];
			s_tlast  <= (i == pkt.size() - 1);
			s_tvalid <= 1'b1;
			do
				@(posedge clk);
			while (!s_tready);
			book.note_byte(pkt[i], i == pkt.size() - 1);
			gap = calm ? 0 : gap_len();
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap)
					@(posedge clk);
			end
		end
	endtask

	task automatic wait_drained();
		if (book.pending() != 0) begin
			// Stop offering so the last byte is not taken a second time.
			s_tvalid <= 1'b0;
			while (book.pending() != 0)
				@(posedge clk);
		end
	endtask

	task automatic random_packet();
		int unsigned kind, n;
		logic        pad, ext;
		logic [3:0]  cc;
		int          pay_len, pad_fill;
		kind     = $urandom_range(0, 99);
		pad      = 1'($urandom);
		ext      = 1'($urandom);
		cc       = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 2));
		pay_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 12);
		pad_fill = pad ? $urandom_range(1, 8) : 0;
		make_rtp(RTP_VERSION, pad, ext, cc, 1'($urandom), 7'($urandom), 16'($urandom),
			$urandom, $urandom, 16'($urandom_range(0, 3)), pay_len, pad_fill, 8'(pad_fill));
		if (kind >= 93) begin
			// Line noise of arbitrary length.
			n = $urandom_range(1, 30);
			pkt.delete();
			repeat (n)
				pkt.push_back(8'($urandom));
		end else if (kind >= 90) begin
			if (ext) begin
				pkt[14 + 4 * cc] = 8'($urandom);
				pkt[15 + 4 * cc] = 8'($urandom);
			end
		end else if (kind >= 85) begin
			pkt[pkt.size() - 1] = 8'($urandom);
		end else if (kind >= 80) begin
			trim($urandom_range(1, pkt.size() - 1));
		end else if (kind >= 75) begin
			pkt[0][7:6] = 2'($urandom);
		end
		send_packet($urandom_range(0, 3) == 0);
	endtask

	initial begin
		int unsigned rand_bytes, pkt_cnt;
		rand_bytes = 0;
		pkt_cnt    = 0;
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed packets: field extremes and every reason for rejection but an overlong packet.
		make_rtp(RTP_VERSION, 0, 0, 0, 0, 0, 16'h0, 32'h0, 32'h0, 0, 1, 0, 0);
		send_packet(1);
		make_rtp(RTP_VERSION, 0, 0, 15, 1, 7'h7F, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			0, 1, 0, 0);
		send_packet(0);
		// Header only, so the payload is empty.
		make_rtp(RTP_VERSION, 0, 0, 0, 0, 7'd96, 16'h1234, 32'h89AB_CDEF, 32'h0102_0304,
			0, 0, 0, 0);
		send_packet(1);
		make_rtp(RTP_VERSION, 0, 0, 0, 0, 7'd8, 16'h5555, 32'hAAAA_5555, 32'h5555_AAAA,
			0, 1, 0, 0);
		trim(11);
		send_packet(1);
		trim(1);
		send_packet(0);
		for (int v = 0; v < 4; v++) begin
			if (2'(v) != RTP_VERSION) begin
				make_rtp(2'(v), 0, 0, 0, 0, 7'd0, 16'h1, 32'h2, 32'h3, 0, 4, 0, 0);
				send_packet(1);
			end
		end
		// CSRC list running past the end of the packet.
		make_rtp(RTP_VERSION, 0, 0, 15, 0, 7'd0, 16'h1, 32'h2, 32'h3, 0, 4, 0, 0);
		trim(20);
		send_packet(1);
		make_rtp(RTP_VERSION, 0, 1, 2, 1, 7'd33, 16'h7, 32'h8, 32'h9, 2, 3, 0, 0);
		send_packet(0);
		// Extension length word far larger than the packet.
		make_rtp(RTP_VERSION, 0, 1, 0, 0, 7'd0, 16'h1, 32'h2, 32'h3, 0, 5, 0, 0);
		pkt[14] = 8'h12;
		send_packet(1);
		// Extension header cut short.
		make_rtp(RTP_VERSION, 0, 1, 0, 0, 7'd0, 16'h1, 32'h2, 32'h3, 0, 0, 0, 0);
		trim(15);
		send_packet(1);
		make_rtp(RTP_VERSION, 1, 0, 0, 0, 7'd11, 16'h1, 32'h2, 32'h3, 0, 4, 3, 3);
		send_packet(1);
		make_rtp(RTP_VERSION, 1, 0, 0, 0, 7'd11, 16'h1, 32'h2, 32'h3, 0, 4, 3, 0);
		send_packet(1);
		make_rtp(RTP_VERSION, 1, 0, 0, 0, 7'd11, 16'h1, 32'h2, 32'h3, 0, 4, 3, 200);
		send_packet(1);
		// Padding that eats the whole payload.
		make_rtp(RTP_VERSION, 1, 0, 0, 0, 7'd11, 16'h1, 32'h2, 32'h3, 0, 0, 5, 5);
		send_packet(1);
		make_rtp(RTP_VERSION, 1, 1, 3, 1, 7'd96, 16'hBEEF, 32'hDEAD_BEEF, 32'hCAFE_F00D,
			1, 10, 4, 4);
		send_packet(0);
		make_rtp(RTP_VERSION, 1, 0, 0, 0, 7'd127, 16'h0, 32'h0, 32'h0, 0, 1, 255, 255);
		send_packet(1);

		// Short packets back to back while the result side holds off, so the
		// descriptor queue fills and s_tready drops.
		hold_req <= 1'b1;
		repeat (8) begin
			make_rtp(RTP_VERSION, 0, 0, 0, 1'($urandom), 7'($urandom), 16'($urandom),
				$urandom, $urandom, 0, 1, 0, 0);
			send_packet(1);
		end
		wait_drained();

		while (rand_bytes < RANDOM_BYTES) begin
			random_packet();
			rand_bytes += pkt.size();
			pkt_cnt++;
			if (pkt_cnt == 30)
				wait_drained();
		end

		wait_drained();
		repeat (20)
			@(posedge clk);
		if (book.errors == 0 && book.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
